[src/dll_pkg.sv]
// Shared constants and types for the doubly linked list engine.
package dll_pkg;
    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IW         = $clog2(CAPACITY + 1);
    localparam int AW         = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    localparam logic [3:0] CMD_INS_HEAD = 4'd0;
    localparam logic [3:0] CMD_INS_TAIL = 4'd1;
    localparam logic [3:0] CMD_INS_POS  = 4'd2;
    localparam logic [3:0] CMD_DEL_HEAD = 4'd3;
    localparam logic [3:0] CMD_DEL_TAIL = 4'd4;
    localparam logic [3:0] CMD_DEL_POS  = 4'd5;
    localparam logic [3:0] CMD_SEARCH   = 4'd6;
    localparam logic [3:0] CMD_FWD      = 4'd7;
    localparam logic [3:0] CMD_BWD      = 4'd8;
    localparam logic [3:0] CMD_COUNT    = 4'd9;
    localparam logic [3:0] CMD_REVERSE  = 4'd10;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // datapath operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;  // capture command, cur = start node
    localparam logic [3:0] OP_RDCUR   = 4'd2;  // issue read of cur node
    localparam logic [3:0] OP_STEP    = 4'd3;  // cur = fw(cur), cnt++
    localparam logic [3:0] OP_BSTEP   = 4'd4;  // cur = bw(cur), cnt++
    localparam logic [3:0] OP_INS1    = 4'd5;  // alloc node, write value/fw/bw
    localparam logic [3:0] OP_INS2    = 4'd6;  // fix neighbor links
    localparam logic [3:0] OP_DEL1    = 4'd7;  // fix neighbor links of cur
    localparam logic [3:0] OP_DEL2    = 4'd8;  // return cur to free chain
    localparam logic [3:0] OP_REV     = 4'd9;
    localparam logic [3:0] OP_SETA    = 4'd10; // a = cur (predecessor), b = fw(cur)
    localparam logic [3:0] OP_ANULL   = 4'd11; // a = NIL, b = first

    typedef struct packed {
        logic [3:0] op;
        logic       start_last;  // latch starts at last node
    } t_cmd;

    typedef struct packed {
        logic [IW-1:0] count;
        logic          full;
        logic          busy;     // free chain still being built after reset
        logic          match;
        logic [6:0]    walk;     // 1-based index of cur
        logic [DATA_WIDTH-1:0] rd_value;
    } t_stat;
endpackage

[src/dll_datapath.sv]
// Link memories, list pointers and walk registers of the list engine.
module dll_datapath
    import dll_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [DATA_WIDTH-1:0] i_value,
    output t_stat                 o_stat
);
    logic [DATA_WIDTH-1:0] r_val_mem [CAPACITY];
    logic [IW-1:0]         r_next_mem [CAPACITY];
    logic [IW-1:0]         r_prev_mem [CAPACITY];
    logic [IW-1:0]  r_head, r_tail, r_free, r_count, r_cur, r_a, r_b;
    logic [6:0]     r_walk;
    logic           r_rev, r_init;
    logic [AW:0]    r_init_idx;
    logic [DATA_WIDTH-1:0] r_key, r_rd_val;
    logic [IW-1:0]  r_rd_next, r_rd_prev, r_rd_free;

    logic [IW-1:0] first_w, last_w, fw_rd, bw_rd;
    logic          cur_ok;
    logic [AW-1:0] cur_a;

    assign first_w = r_rev ? r_tail : r_head;
    assign last_w  = r_rev ? r_head : r_tail;
    assign fw_rd   = r_rev ? r_rd_prev : r_rd_next;
    assign bw_rd   = r_rev ? r_rd_next : r_rd_prev;
    assign cur_ok  = r_cur != NIL;
    assign cur_a   = r_cur[AW-1:0];

    assign o_stat.count    = r_count;
    assign o_stat.full     = (r_count >= NIL) || (r_free >= NIL);
    assign o_stat.busy     = r_init;
    assign o_stat.match    = r_rd_val == r_key;
    assign o_stat.walk     = r_walk;
    assign o_stat.rd_value = r_rd_val;

    // memory reads (registered)
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RDCUR && cur_ok) begin
            r_rd_val  <= r_val_mem[cur_a];
            r_rd_next <= r_next_mem[cur_a];
            r_rd_prev <= r_prev_mem[cur_a];
        end
        if (r_free != NIL) begin
            r_rd_free <= r_next_mem[r_free[AW-1:0]];
        end
    end

    // memory writes: one address per memory per cycle
    always_ff @(posedge i_clk) begin
        if (r_init) begin
            r_next_mem[r_init_idx[AW-1:0]] <= IW'(r_init_idx) + IW'(1);
        end else begin
            unique case (i_cmd.op)
                OP_INS1: begin
                    r_val_mem[r_free[AW-1:0]] <= r_key;
                    if (r_rev) begin
                        r_prev_mem[r_free[AW-1:0]] <= r_b;
                        r_next_mem[r_free[AW-1:0]] <= r_a;
                    end else begin
                        r_next_mem[r_free[AW-1:0]] <= r_b;
                        r_prev_mem[r_free[AW-1:0]] <= r_a;
                    end
                end
                OP_INS2: begin
                    // fw[a] = cur ; bw[b] = cur
                    if (r_a != NIL) begin
                        if (r_rev) r_prev_mem[r_a[AW-1:0]] <= r_cur;
                        else       r_next_mem[r_a[AW-1:0]] <= r_cur;
                    end
                    if (r_b != NIL) begin
                        if (r_rev) r_next_mem[r_b[AW-1:0]] <= r_cur;
                        else       r_prev_mem[r_b[AW-1:0]] <= r_cur;
                    end
                end
                OP_DEL1: begin
                    // fw[bw(cur)] = fw(cur) ; bw[fw(cur)] = bw(cur)
                    if (bw_rd != NIL) begin
                        if (r_rev) r_prev_mem[bw_rd[AW-1:0]] <= fw_rd;
                        else       r_next_mem[bw_rd[AW-1:0]] <= fw_rd;
                    end
                    if (fw_rd != NIL) begin
                        if (r_rev) r_next_mem[fw_rd[AW-1:0]] <= bw_rd;
                        else       r_prev_mem[fw_rd[AW-1:0]] <= bw_rd;
                    end
                end
                OP_DEL2: r_next_mem[cur_a] <= r_free;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= NIL; r_tail <= NIL; r_free <= '0; r_count <= '0;
            r_rev <= 1'b0; r_init <= 1'b1; r_init_idx <= '0;
            r_cur <= NIL; r_walk <= '0; r_a <= NIL; r_b <= NIL;
        end else begin
            if (r_init) begin
                r_init_idx <= r_init_idx + (AW+1)'(1);
                if (r_init_idx == (AW+1)'(CAPACITY - 1)) r_init <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LATCH: begin
                    r_key  <= i_value;
                    r_cur  <= i_cmd.start_last ? last_w : first_w;
                    r_walk <= 7'd1;
                    r_a    <= NIL;
                    r_b    <= first_w;
                    if (i_cmd.start_last) begin
                        r_a <= last_w;
                        r_b <= NIL;
                    end
                end
                OP_STEP: begin
                    r_cur  <= fw_rd;
                    r_walk <= r_walk + 7'd1;
                end
                OP_BSTEP: begin
                    r_cur  <= bw_rd;
                    r_walk <= r_walk + 7'd1;
                end
                OP_SETA: begin
                    r_a <= r_cur;
                    r_b <= fw_rd;
                end
                OP_ANULL: begin
                    r_a <= NIL;
                    r_b <= first_w;
                end
                OP_INS1: begin
                    r_cur   <= r_free;
                    r_free  <= r_rd_free;
                    r_count <= r_count + IW'(1);
                end
                OP_INS2: begin
                    if (r_a == NIL) begin
                        if (r_rev) r_tail <= r_cur; else r_head <= r_cur;
                    end
                    if (r_b == NIL) begin
                        if (r_rev) r_head <= r_cur; else r_tail <= r_cur;
                    end
                end
                OP_DEL1: begin
                    r_a <= bw_rd;
                    r_b <= fw_rd;
                end
                OP_DEL2: begin
                    if (r_a == NIL) begin
                        if (r_rev) r_tail <= r_b; else r_head <= r_b;
                    end
                    if (r_b == NIL) begin
                        if (r_rev) r_head <= r_a; else r_tail <= r_a;
                    end
                    r_free  <= r_cur;
                    r_count <= r_count - IW'(1);
                end
                OP_REV: r_rev <= !r_rev;
                default: ;
            endcase
        end
    end
endmodule

[src/dll_ctrl.sv]
// Command sequencer and result register of the list engine.
module dll_ctrl
    import dll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_opc,
    input  logic [6:0]  i_pos,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic [6:0]  o_position,
    output logic        o_last
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_INS1  = 4'd4;
    localparam logic [3:0] S_INS2  = 4'd5;
    localparam logic [3:0] S_DEL1  = 4'd6;
    localparam logic [3:0] S_DEL2  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_SETA  = 4'd9;
    localparam logic [3:0] S_DELRD = 4'd10;

    logic [3:0] r_state, n_state;
    logic [3:0] r_opc;
    logic [6:0] r_pos;
    logic       r_valid;
    logic [2:0] r_status, n_status;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [6:0] r_position, n_position;
    logic       r_last, n_last;
    logic       emit, can_emit, take;
    logic [6:0] cnt7;
    // pending single result is staged here before S_OUT emits it
    logic       hold_status;
    logic [2:0] r_pend_status;
    logic [6:0] r_pend_pos;

    assign cnt7       = 7'(i_stat.count);
    assign can_emit   = !r_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && !i_stat.busy;
    assign take       = i_valid && o_ready;
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_value    = r_value;
    assign o_position = r_position;
    assign o_last     = r_last;

    always_comb begin
        n_state = r_state; emit = 1'b0;
        n_status = ST_OK; n_value = '0; n_position = '0; n_last = 1'b1;
        o_cmd.op = OP_NONE;
        o_cmd.start_last = (r_opc == CMD_INS_TAIL) || (r_opc == CMD_DEL_TAIL)
                         || (r_opc == CMD_BWD);
        unique case (r_state)
            S_IDLE: if (take) begin
                o_cmd.op = OP_LATCH;
                o_cmd.start_last = (i_opc == CMD_INS_TAIL) || (i_opc == CMD_DEL_TAIL)
                                 || (i_opc == CMD_BWD);
                n_state = S_DISP;
            end
            S_DISP: begin
                priority if (r_opc == CMD_INS_HEAD || r_opc == CMD_INS_TAIL
                             || r_opc == CMD_INS_POS) begin
                    if (i_stat.full) begin
                        n_status = ST_FULL; n_state = S_OUT;
                    end else if (r_opc == CMD_INS_POS
                                 && (r_pos == 7'd0 || r_pos > cnt7 + 7'd1)) begin
                        n_status = ST_BADPOS; n_state = S_OUT;
                    end else if (r_opc == CMD_INS_POS && r_pos != 7'd1) begin
                        o_cmd.op = OP_RDCUR; n_state = S_RD;
                    end else begin
                        n_state = S_INS1;
                    end
                end else if (r_opc == CMD_DEL_HEAD || r_opc == CMD_DEL_TAIL
                             || r_opc == CMD_DEL_POS) begin
                    if (cnt7 == 7'd0) begin
                        n_status = ST_EMPTY; n_state = S_OUT;
                    end else if (r_opc == CMD_DEL_POS
                                 && (r_pos == 7'd0 || r_pos > cnt7)) begin
                        n_status = ST_BADPOS; n_state = S_OUT;
                    end else begin
                        o_cmd.op = OP_RDCUR; n_state = S_RD;
                    end
                end else if (r_opc == CMD_SEARCH) begin
                    if (cnt7 == 7'd0) begin
                        n_status = ST_NOTFOUND; n_state = S_OUT;
                    end else begin
                        o_cmd.op = OP_RDCUR; n_state = S_RD;
                    end
                end else if (r_opc == CMD_FWD || r_opc == CMD_BWD) begin
                    if (cnt7 == 7'd0) begin
                        n_status = ST_EMPTY; n_state = S_OUT;
                    end else begin
                        o_cmd.op = OP_RDCUR; n_state = S_RD;
                    end
                end else if (r_opc == CMD_COUNT) begin
                    n_position = cnt7; n_state = S_OUT;
                end else if (r_opc == CMD_REVERSE) begin
                    o_cmd.op = OP_REV; n_state = S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RD: n_state = S_EVAL;
            S_EVAL: begin
                priority if (r_opc == CMD_INS_POS) begin
                    if (i_stat.walk == r_pos - 7'd1) begin
                        o_cmd.op = OP_SETA; n_state = S_SETA;
                    end else begin
                        o_cmd.op = OP_STEP; n_state = S_DELRD;
                    end
                end else if (r_opc == CMD_DEL_POS && i_stat.walk != r_pos) begin
                    o_cmd.op = OP_STEP; n_state = S_DELRD;
                end else if (r_opc == CMD_DEL_HEAD || r_opc == CMD_DEL_TAIL
                             || r_opc == CMD_DEL_POS) begin
                    o_cmd.op = OP_DEL1; n_state = S_DEL2;
                end else if (r_opc == CMD_SEARCH) begin
                    if (i_stat.match) begin
                        n_position = i_stat.walk; n_state = S_OUT;
                    end else if (i_stat.walk >= cnt7) begin
                        n_status = ST_NOTFOUND; n_state = S_OUT;
                    end else begin
                        o_cmd.op = OP_STEP; n_state = S_DELRD;
                    end
                end else begin
                    // readout: one result per node
                    if (can_emit) begin
                        emit = 1'b1;
                        n_value = i_stat.rd_value;
                        n_last = i_stat.walk >= cnt7;
                        if (i_stat.walk >= cnt7) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.op = (r_opc == CMD_BWD) ? OP_BSTEP : OP_STEP;
                            n_state = S_DELRD;
                        end
                    end
                end
            end
            S_DELRD: begin
                o_cmd.op = OP_RDCUR; n_state = S_RD;
            end
            S_SETA: n_state = S_INS1;
            S_INS1: begin
                if (r_opc == CMD_INS_HEAD || (r_opc == CMD_INS_POS && r_pos == 7'd1)) begin
                    o_cmd.op = OP_ANULL; n_state = S_INS2;
                end else begin
                    o_cmd.op = OP_NONE; n_state = S_INS2;
                end
            end
            S_INS2: begin
                o_cmd.op = OP_INS1; n_state = S_DEL1;
            end
            S_DEL1: begin
                o_cmd.op = OP_INS2; n_state = S_OUT;
            end
            S_DEL2: begin
                o_cmd.op = OP_DEL2; n_state = S_OUT;
            end
            S_OUT: if (can_emit) begin
                emit = 1'b1; n_state = S_IDLE;
                n_status = r_status;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    assign hold_status = (r_state != S_OUT);
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_opc <= i_opc;
            r_pos <= i_pos;
        end
        if (hold_status && n_state == S_OUT) begin
            r_pend_status <= n_status;
            r_pend_pos    <= n_position;
        end
        if (emit) begin
            r_status   <= (r_state == S_OUT) ? r_pend_status : n_status;
            r_value    <= n_value;
            r_position <= (r_state == S_OUT) ? r_pend_pos : n_position;
            r_last     <= n_last;
        end
    end
endmodule

[src/doubly_linked_list_engine.sv]
// Top level of the doubly linked list engine.
// Bounded doubly linked list of up to 32 signed 32-bit values.
// Input channel s_axis: one transaction per command (cmd, value, position).
// Output channel m_axis: one result per command, or one per element for a
// forward or backward readout, the final one flagged by tlast.
// One command is processed at a time; s_axis_tready is high only when idle.
// A command without a walk goes from dispatch straight to the result register;
// head and tail inserts and deletes add their link-update states but no walk.
// Positional insert and delete, search and readout walk the chain node by node
// (step, registered memory read, compare), one node at a time, paced by the
// registered link-memory read.
// After reset the free chain is built while s_axis_tready is held low.
// When m_axis_tready is low the result register holds and the readout walk pauses.
module doubly_linked_list_engine
    import dll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd[3:0], value[35:4], position[42:36]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[2:0], value_res[34:3], position_res[41:35]
    output logic        m_axis_tlast
);
    t_cmd  cmd;
    t_stat stat;
    logic [2:0] status;
    logic [DATA_WIDTH-1:0] vres;
    logic [6:0] pres;

    dll_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_value(s_axis_tdata[35:4]), .o_stat(stat)
    );

    dll_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_opc(s_axis_tdata[3:0]), .i_pos(s_axis_tdata[42:36]),
        .i_stat(stat), .o_cmd(cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(status), .o_value(vres), .o_position(pres), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, pres, vres, status};
endmodule
